>>> src/dsop_pkg.sv
// ----------------------------------------------------------------------------
// DAB sub-channel organisation parser package
// Shared codes, entry type and constant tables for the FIB parser.
// ----------------------------------------------------------------------------
package dsop_pkg;

	localparam int NumSubchannels = 64;
	localparam int FibDataBytes   = 30;
	localparam int IdxW           = $clog2(NumSubchannels);

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ENTRY = 2'd0,
		KIND_CIF   = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	localparam logic [2:0] FigTypeEnd  = 3'd7;
	localparam logic [2:0] FigType0    = 3'd0;
	localparam logic [4:0] FigExtCif   = 5'd0;
	localparam logic [4:0] FigExtSubch = 5'd1;
	localparam logic [2:0] EepOptA     = 3'd0;
	localparam logic [2:0] EepOptB     = 3'd1;

	typedef struct packed {
		logic [5:0]  id;
		logic [9:0]  start_addr;
		logic        short_form;
		logic [2:0]  level;
		logic [9:0]  size;
		logic [11:0] bitrate;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	typedef struct packed {
		logic [9:0]  size;
		logic [2:0]  level;
		logic [11:0] bitrate;
	} uep_t;

	// UEP short-form table: size, protection level and bitrate per index.
	function automatic uep_t uep_lookup(input logic [5:0] idx);
		uep_t r;
		case (idx)
			6'd0:  r = '{10'd16,  3'd5, 12'd32};
			6'd1:  r = '{10'd21,  3'd4, 12'd32};
			6'd2:  r = '{10'd24,  3'd3, 12'd32};
			6'd3:  r = '{10'd29,  3'd2, 12'd32};
			6'd4:  r = '{10'd35,  3'd1, 12'd32};
			6'd5:  r = '{10'd24,  3'd5, 12'd48};
			6'd6:  r = '{10'd29,  3'd4, 12'd48};
			6'd7:  r = '{10'd35,  3'd3, 12'd48};
			6'd8:  r = '{10'd42,  3'd2, 12'd48};
			6'd9:  r = '{10'd52,  3'd1, 12'd48};
			6'd10: r = '{10'd29,  3'd5, 12'd56};
			6'd11: r = '{10'd35,  3'd4, 12'd56};
			6'd12: r = '{10'd42,  3'd3, 12'd56};
			6'd13: r = '{10'd52,  3'd2, 12'd56};
			6'd14: r = '{10'd32,  3'd5, 12'd64};
			6'd15: r = '{10'd42,  3'd4, 12'd64};
			6'd16: r = '{10'd48,  3'd3, 12'd64};
			6'd17: r = '{10'd58,  3'd2, 12'd64};
			6'd18: r = '{10'd70,  3'd1, 12'd64};
			6'd19: r = '{10'd40,  3'd5, 12'd80};
			6'd20: r = '{10'd52,  3'd4, 12'd80};
			6'd21: r = '{10'd58,  3'd3, 12'd80};
			6'd22: r = '{10'd70,  3'd2, 12'd80};
			6'd23: r = '{10'd84,  3'd1, 12'd80};
			6'd24: r = '{10'd48,  3'd5, 12'd96};
			6'd25: r = '{10'd58,  3'd4, 12'd96};
			6'd26: r = '{10'd70,  3'd3, 12'd96};
			6'd27: r = '{10'd84,  3'd2, 12'd96};
			6'd28: r = '{10'd104, 3'd1, 12'd96};
			6'd29: r = '{10'd58,  3'd5, 12'd112};
			6'd30: r = '{10'd70,  3'd4, 12'd112};
			6'd31: r = '{10'd84,  3'd3, 12'd112};
			6'd32: r = '{10'd104, 3'd2, 12'd112};
			6'd33: r = '{10'd64,  3'd5, 12'd128};
			6'd34: r = '{10'd84,  3'd4, 12'd128};
			6'd35: r = '{10'd96,  3'd3, 12'd128};
			6'd36: r = '{10'd116, 3'd2, 12'd128};
			6'd37: r = '{10'd140, 3'd1, 12'd128};
			6'd38: r = '{10'd80,  3'd5, 12'd160};
			6'd39: r = '{10'd104, 3'd4, 12'd160};
			6'd40: r = '{10'd116, 3'd3, 12'd160};
			6'd41: r = '{10'd140, 3'd2, 12'd160};
			6'd42: r = '{10'd168, 3'd1, 12'd160};
			6'd43: r = '{10'd96,  3'd5, 12'd192};
			6'd44: r = '{10'd116, 3'd4, 12'd192};
			6'd45: r = '{10'd140, 3'd3, 12'd192};
			6'd46: r = '{10'd168, 3'd2, 12'd192};
			6'd47: r = '{10'd208, 3'd1, 12'd192};
			6'd48: r = '{10'd116, 3'd5, 12'd224};
			6'd49: r = '{10'd140, 3'd4, 12'd224};
			6'd50: r = '{10'd168, 3'd3, 12'd224};
			6'd51: r = '{10'd208, 3'd2, 12'd224};
			6'd52: r = '{10'd232, 3'd1, 12'd224};
			6'd53: r = '{10'd128, 3'd5, 12'd256};
			6'd54: r = '{10'd168, 3'd4, 12'd256};
			6'd55: r = '{10'd192, 3'd3, 12'd256};
			6'd56: r = '{10'd232, 3'd2, 12'd256};
			6'd57: r = '{10'd280, 3'd1, 12'd256};
			6'd58: r = '{10'd160, 3'd5, 12'd320};
			6'd59: r = '{10'd208, 3'd4, 12'd320};
			6'd60: r = '{10'd280, 3'd2, 12'd320};
			6'd61: r = '{10'd192, 3'd5, 12'd384};
			6'd62: r = '{10'd280, 3'd3, 12'd384};
			default: r = '{10'd416, 3'd1, 12'd384};
		endcase
		return r;
	endfunction

	// ceil(2^16 / d) for the EEP divisors; exact floor division for 10-bit sizes.
	function automatic logic [14:0] eep_recip(input logic prof_b, input logic [1:0] pl);
		logic [14:0] r;
		case ({prof_b, pl})
			3'b000:  r = 15'd5462;
			3'b001:  r = 15'd8192;
			3'b010:  r = 15'd10923;
			3'b011:  r = 15'd16384;
			3'b100:  r = 15'd2428;
			3'b101:  r = 15'd3121;
			3'b110:  r = 15'd3641;
			default: r = 15'd4370;
		endcase
		return r;
	endfunction

endpackage

>>> src/dsop_fib_if.sv
// ----------------------------------------------------------------------------
// FIB item channel
// Valid/ready channel carrying one operation and its FIB byte or table index.
// ----------------------------------------------------------------------------
interface dsop_fib_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] data_byte;
	logic       fib_start;
	logic [5:0] entry_index;

	modport source(output valid, output op, output data_byte, output fib_start,
		output entry_index, input ready);
	modport sink(input valid, input op, input data_byte, input fib_start,
		input entry_index, output ready);
endinterface

>>> src/dsop_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one decoded entry, CIF count or read reply.
// ----------------------------------------------------------------------------
interface dsop_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        entry_in_use;
	logic [5:0]  subchannel_id;
	logic [9:0]  start_addr;
	logic        short_form;
	logic [2:0]  protection_level;
	logic [9:0]  size_cu;
	logic [11:0] bitrate_kbps;
	logic [4:0]  cif_count_high;
	logic [7:0]  cif_count_low;
	logic [1:0]  change_flag;

	modport source(output valid, output kind, output entry_in_use, output subchannel_id,
		output start_addr, output short_form, output protection_level, output size_cu,
		output bitrate_kbps, output cif_count_high, output cif_count_low,
		output change_flag, input ready);
	modport sink(input valid, input kind, input entry_in_use, input subchannel_id,
		input start_addr, input short_form, input protection_level, input size_cu,
		input bitrate_kbps, input cif_count_high, input cif_count_low,
		input change_flag, output ready);
endinterface

>>> src/dsop_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dsop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> src/dab_subchannel_org_parser_core.sv
// ----------------------------------------------------------------------------
// DAB sub-channel organisation parser
// Walks the FIGs of a FIB byte stream, reports FIG 0/0 CIF counts and decodes
// FIG 0/1 sub-channel entries into a 64-entry table that can be read back.
// ----------------------------------------------------------------------------
// Pipeline: an item enters the input register, and its result is presented from
// the result register, which the table RAM read feeds.
// Throughput: one item per cycle, sustained, while the result side is ready.
// Reset: all parser state and every table valid bit are cleared at once by
// arst_n; the table therefore reads as empty straight after reset.
module dab_subchannel_org_parser_core (
	input logic        clk,
	input logic        arst_n,
	dsop_fib_if.sink   fib,
	dsop_res_if.source res
);

	// Input register stage.
	logic                      valid_s1;
	logic [1:0]                op_s1;
	logic [7:0]                byte_s1;
	logic                      start_s1;
	logic [dsop_pkg::IdxW-1:0] idx_s1;

	// Parser state.
	logic [4:0]  fib_pos_q;
	logic [5:0]  fig_end_q;
	logic [15:0] fig_hdr_q;
	logic        fib_ended_q;
	logic [31:0] entry_bytes_q;
	logic [2:0]  entry_cnt_q;
	logic [dsop_pkg::NumSubchannels-1:0] valid_q;

	// Next-state and working values.
	logic [4:0]  pos_n;
	logic [5:0]  fend_n;
	logic [15:0] hdr_n;
	logic        ended_n;
	logic [31:0] eb_n;
	logic [2:0]  cnt_n;
	logic [5:0]  off;
	logic [4:0]  fig_len;
	logic [31:0] x;

	// Result register stage.
	logic                  valid_s2;
	dsop_pkg::kind_t       kind_s2;
	logic                  from_ram_s2;
	logic                  in_use_s2;
	dsop_pkg::entry_t      entry_s2;
	logic [4:0]            cif_hi_s2;
	logic [7:0]            cif_lo_s2;
	logic [1:0]            chg_s2;

	// Stage control and memory requests.
	logic             adv;
	logic             go;
	logic             res_valid;
	dsop_pkg::kind_t  res_kind;
	logic             res_from_ram;
	dsop_pkg::entry_t res_entry;
	logic [4:0]       res_cif_hi;
	logic [7:0]       res_cif_lo;
	logic [1:0]       res_chg;
	logic             wr_en;
	logic             rd_a_en;
	logic             rd_b_en;
	logic             clr;
	dsop_pkg::entry_t ram_a_rdata;
	dsop_pkg::entry_t ram_b_rdata;
	dsop_pkg::entry_t old_entry;
	dsop_pkg::uep_t   uep;
	logic [23:0]      eep_prod;
	logic [7:0]       eep_q;

	// The pipeline moves whenever the result register is free or being emptied.
	assign adv       = !valid_s2 || res.ready;
	assign go        = valid_s1 && adv;
	assign fib.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fib.ready) begin
			valid_s1 <= fib.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fib.ready && fib.valid) begin
			op_s1    <= fib.op;
			byte_s1  <= fib.data_byte;
			start_s1 <= fib.fib_start;
			idx_s1   <= fib.entry_index;
		end
	end

	// The entry bytes as they stand once the current byte is shifted in; the
	// decoders only look at them when an entry completes.
	assign x         = {entry_bytes_q[23:0], byte_s1};
	// Old contents of the entry being collected, held in the shadow RAM read
	// register since the first entry byte; a cleared entry counts as zero.
	assign old_entry = valid_q[x[31:26]] ? ram_b_rdata : '0;
	assign uep       = dsop_pkg::uep_lookup(x[5:0]);
	// Long-form bitrate: size divided by the EEP divisor via a reciprocal.
	assign eep_prod  = 24'(x[9:0]) * 24'(dsop_pkg::eep_recip(x[12], x[11:10]));
	assign eep_q     = eep_prod[23:16];
	assign fig_len   = fig_hdr_q[12:8];

	always_comb begin
		pos_n        = fib_pos_q;
		fend_n       = fig_end_q;
		hdr_n        = fig_hdr_q;
		ended_n      = fib_ended_q;
		eb_n         = entry_bytes_q;
		cnt_n        = entry_cnt_q;
		off          = '0;
		res_valid    = 1'b0;
		res_kind     = dsop_pkg::KIND_ENTRY;
		res_from_ram = 1'b0;
		res_entry    = '0;
		res_cif_hi   = '0;
		res_cif_lo   = '0;
		res_chg      = '0;
		wr_en        = 1'b0;
		rd_a_en      = 1'b0;
		rd_b_en      = 1'b0;
		clr          = 1'b0;
		if (go) begin
			case (op_s1)
				dsop_pkg::OP_READ: begin
					res_valid    = 1'b1;
					res_kind     = dsop_pkg::KIND_READ;
					res_from_ram = 1'b1;
					rd_a_en      = 1'b1;
				end
				dsop_pkg::OP_CLEAR: begin
					clr = 1'b1;
				end
				dsop_pkg::OP_BYTE: begin
					if (start_s1) begin
						pos_n   = '0;
						fend_n  = '0;
						ended_n = 1'b0;
						eb_n    = '0;
						cnt_n   = '0;
					end
					if (!ended_n && pos_n < 5'(dsop_pkg::FibDataBytes)) begin
						if ({1'b0, pos_n} >= fend_n) begin
							// FIG header byte: either the end marker or a new length.
							if (byte_s1[7:5] == dsop_pkg::FigTypeEnd) begin
								ended_n = 1'b1;
							end else begin
								fend_n = {1'b0, pos_n} + {1'b0, byte_s1[4:0]} + 6'd1;
							end
							hdr_n = {byte_s1, 8'd0};
							eb_n  = '0;
							cnt_n = '0;
						end else if (hdr_n[15:13] == dsop_pkg::FigType0) begin
							off = {1'b0, pos_n} + {1'b0, fig_len} + 6'd1 - fend_n;
							if (off == 6'd1) begin
								hdr_n = {hdr_n[15:8], byte_s1};
							end else if (hdr_n[4:0] == dsop_pkg::FigExtCif) begin
								eb_n = {entry_bytes_q[23:0], byte_s1};
								if (off == 6'd5) begin
									res_valid  = 1'b1;
									res_kind   = dsop_pkg::KIND_CIF;
									res_cif_hi = (entry_bytes_q[4:0] >= 5'd20) ?
										entry_bytes_q[4:0] - 5'd20 : entry_bytes_q[4:0];
									res_cif_lo = (byte_s1 >= 8'd250) ?
										byte_s1 - 8'd250 : byte_s1;
									res_chg    = entry_bytes_q[7:6];
								end
							end else if (hdr_n[4:0] == dsop_pkg::FigExtSubch) begin
								if (!(entry_cnt_q == 3'd0 && off + 6'd1 >= {1'b0, fig_len})) begin
									eb_n  = {entry_bytes_q[23:0], byte_s1};
									cnt_n = entry_cnt_q + 3'd1;
									// First entry byte names the sub-channel: fetch its old
									// contents in case a long form keeps them.
									rd_b_en = (entry_cnt_q == 3'd0);
									if (cnt_n == 3'd3 && !byte_s1[7]) begin
										cnt_n                = '0;
										res_entry.id         = x[23:18];
										res_entry.start_addr = x[17:8];
										res_entry.short_form = 1'b1;
										res_entry.level      = uep.level;
										res_entry.size       = uep.size;
										res_entry.bitrate    = uep.bitrate;
										res_valid            = 1'b1;
										wr_en                = 1'b1;
									end else if (cnt_n >= 3'd4) begin
										cnt_n                = '0;
										res_entry.id         = x[31:26];
										res_entry.start_addr = x[25:16];
										res_entry.short_form = 1'b0;
										if (x[14:12] == dsop_pkg::EepOptA) begin
											res_entry.level   = {1'b0, x[11:10]};
											res_entry.size    = x[9:0];
											res_entry.bitrate = {1'b0, eep_q, 3'd0};
										end else if (x[14:12] == dsop_pkg::EepOptB) begin
											res_entry.level   = {1'b1, x[11:10]};
											res_entry.size    = x[9:0];
											res_entry.bitrate = {eep_q[6:0], 5'd0};
										end else begin
											res_entry.level   = old_entry.level;
											res_entry.size    = old_entry.size;
											res_entry.bitrate = old_entry.bitrate;
										end
										res_valid = 1'b1;
										wr_en     = 1'b1;
									end
								end
							end
						end
						pos_n = pos_n + 5'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fib_pos_q     <= '0;
			fig_end_q     <= '0;
			fig_hdr_q     <= '0;
			fib_ended_q   <= 1'b0;
			entry_bytes_q <= '0;
			entry_cnt_q   <= '0;
			valid_q       <= '0;
			valid_s2      <= 1'b0;
		end else begin
			if (go) begin
				fib_pos_q     <= pos_n;
				fig_end_q     <= fend_n;
				fig_hdr_q     <= hdr_n;
				fib_ended_q   <= ended_n;
				entry_bytes_q <= eb_n;
				entry_cnt_q   <= cnt_n;
			end
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[res_entry.id] <= 1'b1;
			end
			if (adv) begin
				valid_s2 <= go && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			kind_s2     <= res_kind;
			from_ram_s2 <= res_from_ram;
			in_use_s2   <= res_from_ram ? valid_q[idx_s1] : (res_kind == dsop_pkg::KIND_ENTRY);
			entry_s2    <= res_entry;
			cif_hi_s2   <= res_cif_hi;
			cif_lo_s2   <= res_cif_lo;
			chg_s2      <= res_chg;
		end
	end

	// Main table copy serves read requests; the shadow copy serves the
	// old-value fetch of an entry being collected.
	dsop_ram #(
		.WIDTH(dsop_pkg::EntryW),
		.DEPTH(dsop_pkg::NumSubchannels)
	) u_ram_a (
		.clk  (clk),
		.we   (wr_en),
		.waddr(res_entry.id),
		.wdata(res_entry),
		.re   (rd_a_en),
		.raddr(idx_s1),
		.rdata(ram_a_rdata)
	);

	dsop_ram #(
		.WIDTH(dsop_pkg::EntryW),
		.DEPTH(dsop_pkg::NumSubchannels)
	) u_ram_b (
		.clk  (clk),
		.we   (wr_en),
		.waddr(res_entry.id),
		.wdata(res_entry),
		.re   (rd_b_en),
		.raddr(byte_s1[7:2]),
		.rdata(ram_b_rdata)
	);

	dsop_pkg::entry_t out_entry;
	// A read of an empty entry returns all zeros.
	assign out_entry = from_ram_s2 ? (in_use_s2 ? ram_a_rdata : '0) : entry_s2;

	assign res.valid            = valid_s2;
	assign res.kind             = kind_s2;
	assign res.entry_in_use     = in_use_s2;
	assign res.subchannel_id    = out_entry.id;
	assign res.start_addr       = out_entry.start_addr;
	assign res.short_form       = out_entry.short_form;
	assign res.protection_level = out_entry.level;
	assign res.size_cu          = out_entry.size;
	assign res.bitrate_kbps     = out_entry.bitrate;
	assign res.cif_count_high   = cif_hi_s2;
	assign res.cif_count_low    = cif_lo_s2;
	assign res.change_flag      = chg_s2;

	// The byte position never runs beyond the end of the FIB.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		fib_pos_q <= 5'(dsop_pkg::FibDataBytes))
		else $error("FIB byte position beyond FIB end");

	// An entry never collects more than four bytes.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q < 3'd4)
		else $error("entry byte count out of range");

	// A clear leaves every entry free on the next cycle.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (valid_q == '0))
		else $error("table not empty after clear");

	// A decoded entry is marked in use on the next cycle.
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(res_entry.id)])
		else $error("decoded entry not marked in use");

endmodule
